[sv/ssrch_pkg.sv]
package ssrch_pkg;

   localparam int PAT_MAX = 32;
   localparam int TXT_MAX = 1024;
   localparam int ALPHA   = 256;

   localparam int BYTE_W  = 8;
   localparam int PAT_AW  = $clog2(PAT_MAX);
   localparam int PCNT_W  = $clog2(PAT_MAX + 1);
   localparam int TXT_AW  = $clog2(TXT_MAX);
   localparam int TCNT_W  = $clog2(TXT_MAX + 1);
   localparam int SHIFT_W = $clog2(PAT_MAX + 2);
   localparam int POS_W   = $clog2(TXT_MAX + PAT_MAX + 2);
   localparam int OFF_W   = 10;
   localparam int RSP_W   = 16;

   typedef enum logic [1:0] {
      REQ_PAT    = 2'd0,
      REQ_TXT    = 2'd1,
      REQ_SEARCH = 2'd2
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLD_RD,
      ST_BLD_WR,
      ST_CMP_CHK,
      ST_CMP_RD,
      ST_CMP_EV,
      ST_SH_RD,
      ST_SH_TBL,
      ST_SH_ADD,
      ST_HIT,
      ST_MISS,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_pat;
      logic load_txt;
      logic init;
      logic bld_rd;
      logic bld_wr;
      logic cmp_rd;
      logic cmp_adv;
      logic sh_rd;
      logic sh_tbl;
      logic sh_add;
      logic res_hit;
      logic res_miss;
   } cmd_type;

   typedef struct packed {
      logic m_zero;
      logic bld_last;
      logic win_fits;
      logic cmp_eq;
      logic cmp_last;
   } stat_type;

endpackage

[sv/ssrch_ctrl.sv]
module ssrch_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_kind,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  ssrch_pkg::stat_type stat,
   output ssrch_pkg::cmd_type  cmd
);
   import ssrch_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      can_take;
   logic      take;
   logic      is_search;

   // A new item may enter while the result waits, except a search, which
   // has to wait until the result leaves.
   assign is_search  = (req_kind == REQ_SEARCH);
   assign can_take   = (state_ff == ST_IDLE) ||
                       ((state_ff == ST_RESP) && (!is_search || rsp_tready));
   assign req_tready = can_take;
   assign take       = req_tvalid && can_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && is_search) begin
               state_in = stat.m_zero ? ST_HIT : ST_BLD_RD;
            end
         end
         ST_BLD_RD: state_in = ST_BLD_WR;
         ST_BLD_WR: begin
            state_in = stat.bld_last ? ST_CMP_CHK : ST_BLD_RD;
         end
         ST_CMP_CHK: begin
            state_in = stat.win_fits ? ST_CMP_RD : ST_MISS;
         end
         ST_CMP_RD: state_in = ST_CMP_EV;
         ST_CMP_EV: begin
            if (!stat.cmp_eq) begin
               state_in = ST_SH_RD;
            end else if (stat.cmp_last) begin
               state_in = ST_HIT;
            end else begin
               state_in = ST_CMP_RD;
            end
         end
         ST_SH_RD:  state_in = ST_SH_TBL;
         ST_SH_TBL: state_in = ST_SH_ADD;
         ST_SH_ADD: state_in = ST_CMP_CHK;
         ST_HIT:    state_in = ST_RESP;
         ST_MISS:   state_in = ST_RESP;
         ST_RESP: begin
            if (take && is_search) begin
               state_in = stat.m_zero ? ST_HIT : ST_BLD_RD;
            end else if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      rsp_tvalid   = 1'b0;
      cmd.load_pat = take && (req_kind == REQ_PAT);
      cmd.load_txt = take && (req_kind == REQ_TXT);
      cmd.init     = take && is_search;
      unique case (state_ff)
         ST_IDLE:    ;
         ST_BLD_RD:  cmd.bld_rd = 1'b1;
         ST_BLD_WR:  cmd.bld_wr = 1'b1;
         ST_CMP_CHK: ;
         ST_CMP_RD:  cmd.cmp_rd = 1'b1;
         ST_CMP_EV:  cmd.cmp_adv = stat.cmp_eq && !stat.cmp_last;
         ST_SH_RD:   cmd.sh_rd = 1'b1;
         ST_SH_TBL:  cmd.sh_tbl = 1'b1;
         ST_SH_ADD:  cmd.sh_add = 1'b1;
         ST_HIT:     cmd.res_hit = 1'b1;
         ST_MISS:    cmd.res_miss = 1'b1;
         ST_RESP:    rsp_tvalid = 1'b1;
         default:    ;
      endcase
   end

endmodule

[sv/ssrch_dp.sv]
module ssrch_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  ssrch_pkg::cmd_type           cmd,
   output ssrch_pkg::stat_type          stat,
   input  logic [ssrch_pkg::BYTE_W-1:0] data_byte,
   output logic                         found,
   output logic [ssrch_pkg::OFF_W-1:0]  match_offset,
   output logic                         overflow
);
   import ssrch_pkg::*;

   logic [BYTE_W-1:0]  pat_mem [PAT_MAX];
   logic [BYTE_W-1:0]  txt_mem [TXT_MAX];
   logic [SHIFT_W-1:0] sh_mem  [ALPHA];
   logic [ALPHA-1:0]   shv_ff;

   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic               pcls_ff, pcls_in;
   logic [TCNT_W-1:0]  tcnt_ff, tcnt_in;
   logic               tcls_ff, tcls_in;
   logic               ovf_ff, ovf_in;

   logic [PAT_AW-1:0]  i_ff;
   logic [PAT_AW-1:0]  k_ff;
   logic [POS_W-1:0]   s_ff;
   logic               past_ff;
   logic [BYTE_W-1:0]  pat_rd_ff;
   logic [BYTE_W-1:0]  txt_rd_ff;
   logic [SHIFT_W-1:0] sh_rd_ff;
   logic               shv_rd_ff;
   logic               found_ff;
   logic [OFF_W-1:0]   off_ff;
   logic               rovf_ff;

   logic               pat_we;
   logic               txt_we;
   logic               clear;
   logic [PAT_AW-1:0]  pat_ra;
   logic [TXT_AW-1:0]  txt_ra;
   logic [BYTE_W-1:0]  sh_ra;
   logic [POS_W:0]     sum_sm;
   logic [POS_W:0]     sum_sk;
   logic [POS_W:0]     n_ext;
   logic [SHIFT_W-1:0] step;
   logic [SHIFT_W-1:0] bld_val;

   assign clear  = cmd.res_hit || cmd.res_miss;
   assign pat_we = cmd.load_pat && !pcls_ff && (data_byte != '0) &&
                   (pcnt_ff < PCNT_W'(PAT_MAX));
   assign txt_we = cmd.load_txt && !tcls_ff && (data_byte != '0) &&
                   (tcnt_ff < TCNT_W'(TXT_MAX));

   assign sum_sm = {1'b0, s_ff} + (POS_W+1)'(pcnt_ff);
   assign sum_sk = {1'b0, s_ff} + (POS_W+1)'(k_ff);
   assign n_ext  = (POS_W+1)'(tcnt_ff);

   assign pat_ra  = cmd.bld_rd ? i_ff : k_ff;
   assign txt_ra  = cmd.sh_rd ? sum_sm[TXT_AW-1:0] : sum_sk[TXT_AW-1:0];
   // The byte just past the text end reads as zero.
   assign sh_ra   = past_ff ? '0 : txt_rd_ff;
   assign step    = shv_rd_ff ? sh_rd_ff : SHIFT_W'(pcnt_ff + 1'b1);
   assign bld_val = SHIFT_W'(pcnt_ff - PCNT_W'(i_ff));

   assign stat.m_zero   = (pcnt_ff == '0);
   assign stat.bld_last = (PCNT_W'(i_ff) + 1'b1) == pcnt_ff;
   assign stat.win_fits = (sum_sm <= n_ext);
   assign stat.cmp_eq   = (pat_rd_ff == txt_rd_ff);
   assign stat.cmp_last = (PCNT_W'(k_ff) + 1'b1) == pcnt_ff;

   assign found        = found_ff;
   assign match_offset = off_ff;
   assign overflow     = rovf_ff;

   always_comb begin
      pcnt_in = pcnt_ff;
      pcls_in = pcls_ff;
      tcnt_in = tcnt_ff;
      tcls_in = tcls_ff;
      ovf_in  = ovf_ff;
      if (cmd.load_pat && !pcls_ff) begin
         if (data_byte == '0) begin
            pcls_in = 1'b1;
         end else if (pat_we) begin
            pcnt_in = pcnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.load_txt && !tcls_ff) begin
         if (data_byte == '0) begin
            tcls_in = 1'b1;
         end else if (txt_we) begin
            tcnt_in = tcnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (clear) begin
         pcnt_in = '0;
         pcls_in = 1'b0;
         tcnt_in = '0;
         tcls_in = 1'b0;
         ovf_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= '0;
         pcls_ff <= 1'b0;
         tcnt_ff <= '0;
         tcls_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         shv_ff  <= '0;
      end else begin
         pcnt_ff <= pcnt_in;
         pcls_ff <= pcls_in;
         tcnt_ff <= tcnt_in;
         tcls_ff <= tcls_in;
         ovf_ff  <= ovf_in;
         if (cmd.init) begin
            shv_ff <= '0;
         end else if (cmd.bld_wr) begin
            shv_ff[pat_rd_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pcnt_ff[PAT_AW-1:0]] <= data_byte;
      end
      if (cmd.bld_rd || cmd.cmp_rd) begin
         pat_rd_ff <= pat_mem[pat_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (txt_we) begin
         txt_mem[tcnt_ff[TXT_AW-1:0]] <= data_byte;
      end
      if (cmd.cmp_rd || cmd.sh_rd) begin
         txt_rd_ff <= txt_mem[txt_ra];
      end
   end

   // Writes go in pattern order, so the last occurrence of a byte wins.
   always_ff @(posedge clock) begin
      if (cmd.bld_wr) begin
         sh_mem[pat_rd_ff] <= bld_val;
      end
      if (cmd.sh_tbl) begin
         sh_rd_ff  <= sh_mem[sh_ra];
         shv_rd_ff <= shv_ff[sh_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         i_ff <= '0;
      end else if (cmd.bld_wr) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.init || cmd.sh_add) begin
         k_ff <= '0;
      end else if (cmd.cmp_adv) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.init) begin
         s_ff <= '0;
      end else if (cmd.sh_add) begin
         s_ff <= s_ff + POS_W'(step);
      end
      if (cmd.sh_rd) begin
         past_ff <= !(sum_sm < n_ext);
      end
      if (clear) begin
         found_ff <= cmd.res_hit;
         off_ff   <= cmd.res_hit ? OFF_W'(s_ff) : '0;
         rovf_ff  <= ovf_ff;
      end
   end

   a_bld_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.bld_wr |-> (PCNT_W'(i_ff) < pcnt_ff))
      else $error("shift table build index runs past the pattern");

   a_txt_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp_rd |-> (sum_sk < n_ext))
      else $error("compare reads text beyond the stored bytes");

   a_shift_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.sh_add |=> (s_ff > $past(s_ff)))
      else $error("window did not advance on a mismatch");

endmodule

[sv/sunday_substring_search.sv]
// Load items (pattern or text byte) are accepted back to back while no search is running.
// A search item reads and writes each pattern byte to build the shift table, then per
// window runs a check, a read and a compare per compared byte, and a shift (text read,
// table read, add), bounded by each store's single read port. The result then waits in RESP.
// Synchronous active-high reset empties both strings and clears the overflow flag.
module sunday_substring_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] found, [10:1] match_offset, [11] overflow, rest zero
);
   import ssrch_pkg::*;

   cmd_type           cmd;
   stat_type          stat;
   logic              found;
   logic [OFF_W-1:0]  match_offset;
   logic              overflow;

   ssrch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ssrch_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .data_byte    (req_tdata),
      .found        (found),
      .match_offset (match_offset),
      .overflow     (overflow)
   );

   assign rsp_tdata = RSP_W'({overflow, match_offset, found});

endmodule

[tb/sv/testbench.sv]
module testbench;
   import ssrch_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int LONG_STALL     = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PRINT_LIMIT    = 40;
   localparam int LONG_TEXT      = 120;

   // Request code that the block must ignore.
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic             overflow;
      logic [OFF_W-1:0] offset;
      logic             found;
   } search_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic [1:0]  req_tuser = 2'd0;    // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [0] found, [10:1] match_offset, [11] overflow

   sunday_substring_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Shadow copy of the two strings.
   logic [7:0]  pat_mem [PAT_MAX];
   logic [7:0]  txt_mem [TXT_MAX];
   int unsigned pat_len = 0;
   int unsigned txt_len = 0;
   bit          pat_done = 1'b0;
   bit          txt_done = 1'b0;
   bit          lost_bytes = 1'b0;

   search_result_type expected_results [$];
   int unsigned    items_applied = 0;
   int unsigned    mismatches = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_idle_pct = 0;
   int unsigned    stall_requests = 0;
   int unsigned    stall_seen = 0;
   int unsigned    stall_left = 0;
   int unsigned    quiet_cycles = 0;

   function automatic search_result_type quick_search();
      int unsigned    m, n, s, k, i;
      int unsigned    skip [ALPHA];
      logic [7:0]     next_byte;
      search_result_type r;
      r = '0;
      r.overflow = lost_bytes;
      m = pat_len;
      n = txt_len;
      if (m == 0) begin
         r.found = 1'b1;
         return r;
      end
      for (i = 0; i < ALPHA; i++) skip[i] = m + 1;
      // Later pattern bytes overwrite earlier ones, so the last occurrence wins.
      for (i = 0; i < m; i++) skip[pat_mem[i]] = m - i;
      s = 0;
      while (s + m <= n) begin
         k = 0;
         while (k < m && pat_mem[k] == txt_mem[s + k]) k++;
         if (k == m) begin
            r.found = 1'b1;
            r.offset = s[OFF_W-1:0];
            return r;
         end
         next_byte = (s + m < n) ? txt_mem[s + m] : 8'h00;
         s += skip[next_byte];
      end
      return r;
   endfunction

   task automatic apply_item(logic [1:0] kind, logic [7:0] data);
      case (kind)
         REQ_PAT: if (!pat_done) begin
            items_applied++;
            if (data == 8'h00) pat_done = 1'b1;
            else if (pat_len < PAT_MAX) begin
               pat_mem[pat_len] = data;
               pat_len++;
            end else lost_bytes = 1'b1;
         end
         REQ_TXT: if (!txt_done) begin
            items_applied++;
            if (data == 8'h00) txt_done = 1'b1;
            else if (txt_len < TXT_MAX) begin
               txt_mem[txt_len] = data;
               txt_len++;
            end else lost_bytes = 1'b1;
         end
         REQ_SEARCH: begin
            items_applied++;
            expected_results = {expected_results, quick_search()};
            pat_len = 0;
            txt_len = 0;
            pat_done = 1'b0;
            txt_done = 1'b0;
            lost_bytes = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_result(logic [15:0] word);
      search_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result %h with no search pending", word));
         return;
      end
      want = expected_results.pop_front();
      if (word[0] !== want.found)
         report_mismatch($sformatf("found %b, expected %b", word[0], want.found));
      if (word[10:1] !== want.offset)
         report_mismatch($sformatf("match_offset %0d, expected %0d", word[10:1], want.offset));
      if (word[11] !== want.overflow)
         report_mismatch($sformatf("overflow %b, expected %b", word[11], want.overflow));
      if (word[15:12] !== 4'h0)
         report_mismatch($sformatf("padding bits %h, expected zero", word[15:12]));
   endtask

   // Monitors both channels and drives the result-side ready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) check_result(rsp_tdata);
      if (!reset && req_tvalid === 1'b1 && req_tready === 1'b1) apply_item(req_tuser, req_tdata);
      if (stall_requests != stall_seen) begin
         stall_seen = stall_requests;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sunday_substring_search verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a rising edge; returns at the edge where the item is accepted.
   task automatic send_item(logic [1:0] kind, logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic send_string(logic [1:0] kind, string s, bit close);
      int i;
      for (i = 0; i < s.len(); i++) send_item(kind, s[i]);
      if (close) send_item(kind, 8'h00);
   endtask

   function automatic logic [7:0] pick_byte(logic [7:0] alph [3]);
      if ($urandom_range(7) == 0) return 8'($urandom_range(255, 1));
      return alph[$urandom_range(2)];
   endfunction

   task automatic test_empty_pattern();
      send_item(REQ_SEARCH, 8'hA5);
      send_string(REQ_TXT, "abc", 1'b1);
      send_item(REQ_SEARCH, 8'h00);
   endtask

   // Bytes after a terminator and unknown requests must leave the strings alone.
   task automatic test_terminator_and_unknown();
      send_string(REQ_PAT, "ab", 1'b1);
      send_string(REQ_PAT, "zz", 1'b0);
      send_item(REQ_UNKNOWN, 8'hFF);
      send_string(REQ_TXT, "cdab", 1'b1);
      send_string(REQ_TXT, "x", 1'b1);
      send_item(REQ_UNKNOWN, 8'h00);
      send_item(REQ_SEARCH, 8'hFF);
   endtask

   task automatic test_edge_cases();
      // Pattern longer than the text.
      send_string(REQ_PAT, "abc", 1'b0);
      send_string(REQ_TXT, "ab", 1'b0);
      send_item(REQ_SEARCH, 8'h00);
      // The last shift reads the byte past the text end as zero.
      send_string(REQ_PAT, "ce", 1'b1);
      send_string(REQ_TXT, "abcd", 1'b1);
      send_item(REQ_SEARCH, 8'h00);
      // Extreme byte values.
      send_item(REQ_PAT, 8'hFF);
      send_item(REQ_PAT, 8'h01);
      send_item(REQ_TXT, 8'h80);
      send_item(REQ_TXT, 8'hFF);
      send_item(REQ_TXT, 8'h01);
      send_item(REQ_TXT, 8'h7F);
      send_item(REQ_SEARCH, 8'h00);
   endtask

   task automatic test_capacity();
      int i;
      // Pattern store overflows; text is too short for the stored pattern.
      for (i = 0; i < PAT_MAX + 2; i++) send_item(REQ_PAT, "a");
      send_string(REQ_TXT, "aaaaa", 1'b1);
      send_item(REQ_SEARCH, 8'h00);
      // A long text whose first match sits close to its end.
      send_string(REQ_PAT, "z", 1'b1);
      for (i = 0; i < LONG_TEXT - 3; i++) send_item(REQ_TXT, "a");
      send_string(REQ_TXT, "zzy", 1'b1);
      send_item(REQ_SEARCH, 8'h00);
   endtask

   task automatic test_random_searches(int unsigned quota);
      int unsigned goal, plen, tlen, pos, i;
      logic [7:0]  alph [3];
      logic [7:0]  pat_q [$];
      logic [7:0]  txt_q [$];
      goal = items_applied + quota;
      while (items_applied < goal) begin
         foreach (alph[j]) alph[j] = 8'($urandom_range(255, 1));
         plen = ($urandom_range(15) == 0) ? $urandom_range(PAT_MAX + 2, PAT_MAX - 4)
                                           : $urandom_range(6);
         tlen = ($urandom_range(15) == 0) ? $urandom_range(80, 40) : $urandom_range(24);
         pat_q.delete();
         txt_q.delete();
         for (i = 0; i < plen; i++) pat_q = {pat_q, pick_byte(alph)};
         for (i = 0; i < tlen; i++) txt_q = {txt_q, pick_byte(alph)};
         if (plen <= tlen && $urandom_range(1)) begin
            pos = $urandom_range(tlen - plen);
            for (i = 0; i < plen; i++) txt_q[pos + i] = pat_q[i];
         end
         if ($urandom_range(1)) begin
            pat_q = {pat_q, 8'h00};
            if ($urandom_range(3) == 0) pat_q = {pat_q, 8'($urandom_range(255))};
         end
         if ($urandom_range(1)) begin
            txt_q = {txt_q, 8'h00};
            if ($urandom_range(3) == 0) txt_q = {txt_q, 8'($urandom_range(255))};
         end
         while (pat_q.size() != 0 || txt_q.size() != 0) begin
            if ($urandom_range(19) == 0) send_item(REQ_UNKNOWN, 8'($urandom_range(255)));
            if (txt_q.size() == 0 || (pat_q.size() != 0 && $urandom_range(1)))
               send_item(REQ_PAT, pat_q.pop_front());
            else
               send_item(REQ_TXT, txt_q.pop_front());
         end
         // A few sequences skip the search and run into the next one.
         if ($urandom_range(9) != 0) send_item(REQ_SEARCH, 8'($urandom_range(255)));
      end
   endtask

   // The receiver holds off long enough for the block to back up its input.
   task automatic test_result_backpressure();
      int i;
      stall_requests++;
      for (i = 0; i < 4; i++) begin
         send_string(REQ_PAT, "q", 1'b1);
         send_string(REQ_TXT, "pq", 1'b0);
         send_item(REQ_SEARCH, 8'h00);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 46;
      test_empty_pattern();
      test_terminator_and_unknown();
      test_edge_cases();
      test_capacity();
      test_random_searches(110);
      send_idle_pct = 46;
      recv_idle_pct = 31;
      test_random_searches(110);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_searches(110);
      test_result_backpressure();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sunday_substring_search verification clean");
      end else begin
         $display("sunday_substring_search verification failed");
      end
      $finish;
   end

endmodule
